// File: hdl/u8v_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8v_pkg;

    // Verdict codes given on the last byte of a string.
    typedef enum logic [1:0] {
        VERDICT_INVALID = 2'd0,
        VERDICT_ASCII   = 2'd1,
        VERDICT_MULTI   = 2'd2
    } t_verdict;

    // Scanner state carried from one byte to the next.
    typedef struct packed {
        logic [2:0] cont_left;
        logic [7:0] lead_value;
        logic       expect_second;
        logic       seen_multibyte;
        logic       failed;
    } t_scan_state;

    // Lead bytes whose minimal encodings are checked against the second byte.
    localparam logic [7:0] LEAD_OVERLONG_3 = 8'hE0;
    localparam logic [7:0] LEAD_OVERLONG_4 = 8'hF0;
    localparam logic [7:0] LEAD_OVERLONG_5 = 8'hF8;
    localparam logic [7:0] LEAD_OVERLONG_6 = 8'hFC;

    // Bytes that never appear in a valid string.
    localparam logic [7:0] BYTE_BAD_FE = 8'hFE;
    localparam logic [7:0] BYTE_BAD_FF = 8'hFF;

endpackage

`default_nettype wire

// File: hdl/u8v_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface u8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

`default_nettype wire

// File: hdl/u8v_verdict_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface u8v_verdict_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

// File: hdl/u8v_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module u8v_scan
    import u8v_pkg::*;
(
    input  wire t_scan_state i_state,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_last_byte,
    output t_scan_state      o_state,
    output t_verdict         o_verdict
);

    t_scan_state n_state;
    logic [2:0]  needed;
    logic        overlong;

    // Number of continuation bytes owed after a lead byte 11xxxxxx.
    always_comb begin
        priority if (!i_byte_value[5]) begin
            needed = 3'd1;
        end else if (!i_byte_value[4]) begin
            needed = 3'd2;
        end else if (!i_byte_value[3]) begin
            needed = 3'd3;
        end else if (!i_byte_value[2]) begin
            needed = 3'd4;
        end else begin
            needed = 3'd5;
        end
    end

    // A second byte that shows the lead byte used more bytes than it needed.
    assign overlong =
        (i_state.lead_value == LEAD_OVERLONG_3 && i_byte_value[5] == 1'b0) ||
        (i_state.lead_value == LEAD_OVERLONG_4 && i_byte_value[5:4] == 2'b00) ||
        (i_state.lead_value == LEAD_OVERLONG_5 && i_byte_value[5:3] == 3'b000) ||
        (i_state.lead_value == LEAD_OVERLONG_6 && i_byte_value[5:2] == 4'b0000);

    // Advance the scan by one byte.
    always_comb begin
        n_state = i_state;
        if (i_state.cont_left == 3'd0) begin
            if (i_byte_value[7]) begin
                n_state.seen_multibyte = 1'b1;
                if (!i_byte_value[6]) begin
                    // A continuation byte with no open sequence.
                    n_state.failed = 1'b1;
                end else if (i_byte_value == BYTE_BAD_FE || i_byte_value == BYTE_BAD_FF) begin
                    n_state.failed = 1'b1;
                end else if (i_byte_value[5] == 1'b0 && i_byte_value[4:1] == 4'b0000) begin
                    // Two-byte lead that can only encode an ASCII value.
                    n_state.failed = 1'b1;
                end else begin
                    n_state.cont_left     = needed;
                    n_state.lead_value    = i_byte_value;
                    n_state.expect_second = 1'b1;
                end
            end
        end else begin
            if (i_byte_value[7:6] != 2'b10) begin
                // A continuation was owed; the sequence is dropped.
                n_state.failed        = 1'b1;
                n_state.cont_left     = 3'd0;
                n_state.expect_second = 1'b0;
            end else begin
                if (i_state.expect_second) begin
                    if (overlong) begin
                        n_state.failed = 1'b1;
                    end
                    n_state.expect_second = 1'b0;
                end
                n_state.cont_left = i_state.cont_left - 3'd1;
            end
        end
    end

    // Verdict on the last byte; the state then starts over for the next string.
    always_comb begin
        o_state = n_state;
        if (n_state.failed || n_state.cont_left != 3'd0) begin
            o_verdict = VERDICT_INVALID;
        end else if (n_state.seen_multibyte) begin
            o_verdict = VERDICT_MULTI;
        end else begin
            o_verdict = VERDICT_ASCII;
        end
        if (i_last_byte) begin
            o_state = '0;
        end
    end

endmodule

`default_nettype wire

// File: hdl/utf8_stream_validator_core.sv
// Latency: the verdict is valid in the cycle after the last byte of a string is accepted.
// Throughput: one byte per cycle while the input is not stalled; the scan state is registered on each accepted byte.
// Input stalls in any cycle where a verdict is waiting and the output is not ready for it.
// Reset (i_rst_n low at a clock edge) clears the scan state and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_validator_core
    import u8v_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    u8v_byte_if.sink       i_byte,
    u8v_verdict_if.source  o_verdict
);

    t_scan_state r_state;
    t_scan_state n_state;
    t_verdict    n_verdict;
    logic [1:0]  r_verdict;
    logic        r_out_valid;
    logic        in_accept;

    // Input is taken whenever the result register is free or being emptied.
    assign i_byte.ready = !r_out_valid || o_verdict.ready;
    assign in_accept    = i_byte.valid && i_byte.ready;

    u8v_scan u_scan (
        .i_state      (r_state),
        .i_byte_value (i_byte.byte_value),
        .i_last_byte  (i_byte.last_byte),
        .o_state      (n_state),
        .o_verdict    (n_verdict)
    );

    // Scan state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Result register: loaded on the last byte, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && i_byte.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_verdict.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_byte.last_byte) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_verdict.valid   = r_out_valid;
    assign o_verdict.verdict = r_verdict;

`ifndef SYNTHESIS
    // A pending second byte implies an open sequence.
    a_second_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.expect_second |-> r_state.cont_left != 3'd0)
        else $error("second-byte flag set with no open sequence");

    // No sequence owes more than five continuation bytes.
    a_cont_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.cont_left <= 3'd5)
        else $error("continuation count out of range");

    // The last byte clears the state and produces a verdict.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_byte.last_byte |=> r_state == '0 && r_out_valid)
        else $error("last byte did not clear state or raise a verdict");

    // The unused verdict code never leaves the block.
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_verdict != 2'b11)
        else $error("undefined verdict code");
`endif

endmodule

`default_nettype wire
